[rtl/core/fxalu_pkg.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared word width, operation codes, item types and pipeline control struct.
// ----------------------------------------------------------------------------
package fxalu_pkg;

    // Raw word width, fixed by the item fields.
    localparam int WORD_BITS = 32;

    // Default number of fraction bits (Q24.8).
    localparam int FRAC_BITS_DEF = 8;

    // Operation codes.
    localparam logic [3:0] KIND_ADD      = 4'd0;
    localparam logic [3:0] KIND_SUB      = 4'd1;
    localparam logic [3:0] KIND_MUL      = 4'd2;
    localparam logic [3:0] KIND_DIV      = 4'd3;
    localparam logic [3:0] KIND_MIN      = 4'd4;
    localparam logic [3:0] KIND_MAX      = 4'd5;
    localparam logic [3:0] KIND_INC      = 4'd6;
    localparam logic [3:0] KIND_DEC      = 4'd7;
    localparam logic [3:0] KIND_FROM_INT = 4'd8;
    localparam logic [3:0] KIND_TO_INT   = 4'd9;

    // One input item.
    typedef struct packed {
        logic [3:0]                  kind;
        logic signed [WORD_BITS-1:0] operand_a;
        logic signed [WORD_BITS-1:0] operand_b;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic signed [WORD_BITS-1:0] result;
        logic                        less;
        logic                        equal;
        logic                        greater;
        logic                        div_by_zero;
    } t_out_item;

    // Control that travels with each item down the pipeline.
    typedef struct packed {
        logic valid;
        logic is_div;
        logic neg;
        logic div_by_zero;
        logic less;
        logic equal;
        logic greater;
    } t_ctl;

endpackage

[rtl/core/fxalu_prep.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU operand stage
// Computes compare flags, the multiply and all other non-divide results, and
// prepares the divider's dividend magnitude, divisor magnitude and sign.
// ----------------------------------------------------------------------------
module fxalu_prep #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  logic                                        i_valid,
    input  fxalu_pkg::t_in_item                         i_item,
    output fxalu_pkg::t_ctl                             o_ctl,
    output logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   o_acc,
    output logic [fxalu_pkg::WORD_BITS-1:0]             o_rem,
    output logic [fxalu_pkg::WORD_BITS-1:0]             o_dvs
);

    localparam int W = fxalu_pkg::WORD_BITS;
    localparam int N = W + FRAC_BITS;

    logic signed [W-1:0]   sa;
    logic signed [W-1:0]   sb;
    logic [W-1:0]          ua;
    logic [W-1:0]          ub;
    logic signed [2*W-1:0] prod;
    logic                  lt;
    logic                  gt;
    logic                  eq;
    logic                  b_zero;
    logic                  is_div;
    logic                  dz;
    logic                  na;
    logic                  nb;
    logic [W-1:0]          ma;
    logic [W-1:0]          mb;
    logic [W-1:0]          res;

    fxalu_pkg::t_ctl       r_ctl;
    fxalu_pkg::t_ctl       n_ctl;
    logic [N-1:0]          r_acc;
    logic [N-1:0]          n_acc;
    logic [W-1:0]          r_dvs;

    assign sa = $signed(i_item.operand_a);
    assign sb = $signed(i_item.operand_b);
    assign ua = i_item.operand_a;
    assign ub = i_item.operand_b;

    // Signed compare flags, given for every operation.
    assign lt = sa < sb;
    assign gt = sb < sa;
    assign eq = ua == ub;

    // Full signed product; the result word is taken above the fraction bits.
    assign prod = sa * sb;

    // Divide control and operand magnitudes.
    assign b_zero = ub == '0;
    assign is_div = (i_item.kind == fxalu_pkg::KIND_DIV) && !b_zero;
    assign dz     = (i_item.kind == fxalu_pkg::KIND_DIV) && b_zero;
    assign na     = ua[W-1];
    assign nb     = ub[W-1];
    assign ma     = na ? (~ua + W'(1)) : ua;
    assign mb     = nb ? (~ub + W'(1)) : ub;

    // Results of the operations that finish in this stage.
    always_comb begin
        case (i_item.kind)
            fxalu_pkg::KIND_ADD:      res = ua + ub;
            fxalu_pkg::KIND_SUB:      res = ua - ub;
            fxalu_pkg::KIND_MUL:      res = prod[FRAC_BITS+W-1:FRAC_BITS];
            fxalu_pkg::KIND_MIN:      res = lt ? ua : ub;
            fxalu_pkg::KIND_MAX:      res = gt ? ua : ub;
            fxalu_pkg::KIND_INC:      res = ua + W'(1);
            fxalu_pkg::KIND_DEC:      res = ua - W'(1);
            fxalu_pkg::KIND_FROM_INT: res = ua << FRAC_BITS;
            fxalu_pkg::KIND_TO_INT:   res = W'(sa >>> FRAC_BITS);
            default:                  res = '0;
        endcase
    end

    // The accumulator holds the shifted dividend for a divide and the
    // finished result for everything else.
    always_comb begin
        n_ctl.valid       = i_valid;
        n_ctl.is_div      = is_div;
        n_ctl.neg         = is_div && (na != nb);
        n_ctl.div_by_zero = dz;
        n_ctl.less        = lt;
        n_ctl.equal       = eq;
        n_ctl.greater     = gt;
        if (is_div) begin
            n_acc = N'(ma) << FRAC_BITS;
        end else begin
            n_acc = N'(res);
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
            r_acc <= n_acc;
            r_dvs <= mb;
        end
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_rem = '0;
    assign o_dvs = r_dvs;

endmodule

[rtl/core/fxalu_div_step.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU divide step
// One restoring-division step: produces one quotient bit per stage. Items
// that are not divides pass through unchanged.
// ----------------------------------------------------------------------------
module fxalu_div_step #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  fxalu_pkg::t_ctl                             i_ctl,
    input  logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   i_acc,
    input  logic [fxalu_pkg::WORD_BITS-1:0]             i_rem,
    input  logic [fxalu_pkg::WORD_BITS-1:0]             i_dvs,
    output fxalu_pkg::t_ctl                             o_ctl,
    output logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   o_acc,
    output logic [fxalu_pkg::WORD_BITS-1:0]             o_rem,
    output logic [fxalu_pkg::WORD_BITS-1:0]             o_dvs
);

    localparam int W = fxalu_pkg::WORD_BITS;
    localparam int N = W + FRAC_BITS;

    logic [W-1:0]    shifted;
    logic [W:0]      diff;
    logic            borrow;
    logic [N-1:0]    n_acc;
    logic [W-1:0]    n_rem;

    fxalu_pkg::t_ctl r_ctl;
    logic [N-1:0]    r_acc;
    logic [W-1:0]    r_rem;
    logic [W-1:0]    r_dvs;

    // The partial remainder stays below the divisor magnitude, which is at
    // most half the word range, so bringing down one bit still fits a word.
    assign shifted = {i_rem[W-2:0], i_acc[N-1]};
    assign diff    = {1'b0, shifted} - {1'b0, i_dvs};
    assign borrow  = diff[W];

    // Trial subtract; the quotient bit enters at the bottom of the accumulator.
    always_comb begin
        if (i_ctl.is_div) begin
            n_acc = {i_acc[N-2:0], ~borrow};
            n_rem = borrow ? shifted : diff[W-1:0];
        end else begin
            n_acc = i_acc;
            n_rem = i_rem;
        end
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_dvs <= i_dvs;
        end
    end

    assign o_ctl = r_ctl;
    assign o_acc = r_acc;
    assign o_rem = r_rem;
    assign o_dvs = r_dvs;

endmodule

[rtl/core/fxalu_post.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU result stage
// Applies the quotient sign, wraps to the word and assembles the result item.
// ----------------------------------------------------------------------------
module fxalu_post #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_en,
    input  fxalu_pkg::t_ctl                             i_ctl,
    input  logic [fxalu_pkg::WORD_BITS+FRAC_BITS-1:0]   i_acc,
    output logic                                        o_valid,
    output fxalu_pkg::t_out_item                        o_item
);

    localparam int W = fxalu_pkg::WORD_BITS;

    logic [W-1:0]         qw;
    fxalu_pkg::t_out_item n_item;
    fxalu_pkg::t_out_item r_item;
    logic                 r_valid;

    // Low word of the accumulator, negated for a divide of mixed signs.
    assign qw = i_acc[W-1:0];

    always_comb begin
        n_item.result      = i_ctl.neg ? (~qw + W'(1)) : qw;
        n_item.less        = i_ctl.less;
        n_item.equal       = i_ctl.equal;
        n_item.greater     = i_ctl.greater;
        n_item.div_by_zero = i_ctl.div_by_zero;
    end

    // Stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
            r_item  <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/core/fxalu_skid.sv]
// ----------------------------------------------------------------------------
// Fixed-point ALU output buffer
// Output register with a skid entry; its ready comes from a register, so the
// pipeline keeps moving while one finished item waits downstream.
// ----------------------------------------------------------------------------
module fxalu_skid (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  fxalu_pkg::t_out_item i_item,
    output logic                 o_ready,
    output logic                 o_valid,
    output fxalu_pkg::t_out_item o_item,
    input  logic                 i_ready
);

    logic                 r_out_valid;
    fxalu_pkg::t_out_item r_out;
    logic                 r_skid_valid;
    fxalu_pkg::t_out_item r_skid;
    logic                 out_free;

    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = !r_skid_valid;

    // Refill the output register from the skid entry first, then from the
    // pipeline; park an incoming item in the skid entry while the output holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
                r_out       <= i_item;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
            r_skid       <= i_item;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

`ifndef ASSERT_OFF
    // The skid entry fills only behind a held output item.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry holds an item while the output register is empty");

    // Nothing is presented in the cycle after a reset edge.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid && !r_skid_valid)
        else $error("output buffer not empty after reset");
`endif

endmodule

[rtl/core/fixed_point_q24_8_alu.sv]
// Every item (Q24.8 by default) takes the same path whatever the operation: the
// operand stage, one quotient bit per divider step, result stage, output register.
// Throughput: one item per cycle while the skid entry is free.
// Reset is synchronous and active low; it clears all valid bits, not payloads.
// ----------------------------------------------------------------------------
// Fixed-point Q24.8 ALU
// Pipelined signed fixed-point ALU: operand stage, one restoring-division
// step per stage, result stage and an output buffer with a skid entry.
// ----------------------------------------------------------------------------
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fxalu_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  fxalu_pkg::t_in_item  i_item,
    output logic                 o_valid,
    input  logic                 i_ready,
    output fxalu_pkg::t_out_item o_item
);

    localparam int W = fxalu_pkg::WORD_BITS;
    localparam int N = W + FRAC_BITS;

    logic                 en;
    fxalu_pkg::t_ctl      ctl [0:N];
    logic [N-1:0]         acc [0:N];
    logic [W-1:0]         rem [0:N];
    logic [W-1:0]         dvs [0:N];
    logic                 post_valid;
    fxalu_pkg::t_out_item post_item;

    // The whole pipeline advances whenever the skid entry is free.
    assign o_ready = en;

    // Operand stage.
    fxalu_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_ctl   (ctl[0]),
        .o_acc   (acc[0]),
        .o_rem   (rem[0]),
        .o_dvs   (dvs[0])
    );

    // Divider steps, one quotient bit each.
    for (genvar k = 0; k < N; k++) begin : g_step
        fxalu_div_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (ctl[k]),
            .i_acc   (acc[k]),
            .i_rem   (rem[k]),
            .i_dvs   (dvs[k]),
            .o_ctl   (ctl[k+1]),
            .o_acc   (acc[k+1]),
            .o_rem   (rem[k+1]),
            .o_dvs   (dvs[k+1])
        );
    end

    // Result stage.
    fxalu_post #(
        .FRAC_BITS (FRAC_BITS)
    ) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_ctl   (ctl[N]),
        .i_acc   (acc[N]),
        .o_valid (post_valid),
        .o_item  (post_item)
    );

    // Output register and skid entry.
    fxalu_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (post_valid),
        .i_item  (post_item),
        .o_ready (en),
        .o_valid (o_valid),
        .o_item  (o_item),
        .i_ready (i_ready)
    );

`ifndef ASSERT_OFF
    // Exactly one compare flag is set on every result item.
    a_one_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $countones({o_item.less, o_item.equal, o_item.greater}) == 1)
        else $error("compare flags are not exclusive");

    // A zero divisor forces a zero result.
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.div_by_zero |-> o_item.result == '0)
        else $error("divide by zero item carries a nonzero result");
`endif

endmodule
